FILE: rtl/lfq_pkg.sv
// ============================================================================
// lfq_pkg
// Shared types and constants for the line framer with line queue.
// ============================================================================
package lfq_pkg;

    typedef enum logic [3:0] {
        ST_STORED      = 4'd0,
        ST_CR_IGNORED  = 4'd1,
        ST_QUEUED      = 4'd2,
        ST_EMPTY_IGN   = 4'd3,
        ST_DROP_FULL   = 4'd4,
        ST_DISC_START  = 4'd5,
        ST_DISCARDED   = 4'd6,
        ST_DISC_END    = 4'd7,
        ST_LINE_BYTE   = 4'd8,
        ST_QUEUE_EMPTY = 4'd9,
        ST_BUF_SMALL   = 4'd10
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'b01,
        FSM_STREAM = 2'b10
    } fsm_t;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

endpackage

FILE: rtl/line_framer_with_line_queue.sv
// ============================================================================
// line_framer_with_line_queue
// Assembles received bytes into lines and queues complete lines in a ring.
// ============================================================================
// A received byte is taken and its result shows on the next cycle; busy
// stays low while no line streams, so bytes may come every cycle. A pop
// that fails (ring empty or reader buffer too small) also answers on the
// next cycle. A pop that succeeds holds busy high while the read counter
// walks the line row (1 to MAX_LINE-1 bytes) through the store's single
// read port, one byte per cycle; the bytes follow one per cycle out of the
// store's registered read port, the final one marked by last.
// Results are shown for one cycle under strobe and cannot be held off.
module line_framer_with_line_queue #(
    parameter int MAX_LINE    = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       action,
    input  logic [7:0] rx_byte,
    input  logic [6:0] reader_capacity,
    output logic       strobe,
    output logic [3:0] status,
    output logic [7:0] line_byte,
    output logic       last,
    output logic [2:0] lines_waiting
);

    localparam int ROWS  = QUEUE_DEPTH + 1;
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(MAX_LINE);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lfq_pkg::fsm_t        state_reg, state_next;
    logic [COL_W-1:0]     asm_len_reg, asm_len_next;
    logic                 discarding_reg, discarding_next;
    logic [ROW_W-1:0]     read_row_reg, read_row_next;
    logic [ROW_W-1:0]     write_row_reg, write_row_next;
    logic [ROW_W-1:0]     pop_row_reg, pop_row_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [COL_W-1:0]     len_m1_reg, len_m1_next;
    logic [COL_W-1:0]     lengths_reg [ROWS];

    logic                 strobe_reg, strobe_next;
    lfq_pkg::status_t     status_reg, status_next;
    logic                 last_reg, last_next;
    logic                 sel_reg, sel_next;
    logic [2:0]           lines_reg, lines_next;

    logic                 wr_en;
    logic                 len_wr;
    logic [7:0]           rd_data;
    logic [COL_W-1:0]     head_len;
    logic [CNT_W+2:0]     count_ext;
    logic                 accept;

    assign accept   = start && (state_reg == lfq_pkg::FSM_IDLE);
    assign head_len = lengths_reg[read_row_reg];

    lfq_line_store #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_row  (write_row_reg),
        .wr_col  (asm_len_reg),
        .wr_data (rx_byte),
        .rd_row  (pop_row_reg),
        .rd_col  (col_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        asm_len_next    = asm_len_reg;
        discarding_next = discarding_reg;
        read_row_next   = read_row_reg;
        write_row_next  = write_row_reg;
        pop_row_next    = pop_row_reg;
        count_next      = count_reg;
        col_next        = col_reg;
        len_m1_next     = len_m1_reg;
        strobe_next     = 1'b0;
        status_next     = status_reg;
        last_next       = last_reg;
        sel_next        = 1'b0;
        wr_en           = 1'b0;
        len_wr          = 1'b0;

        unique case (state_reg)
            lfq_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    if (!action)
                    begin
                        priority if (rx_byte == lfq_pkg::CH_CR)
                        begin
                            status_next = lfq_pkg::ST_CR_IGNORED;
                        end
                        else if (rx_byte == lfq_pkg::CH_LF)
                        begin
                            asm_len_next = '0;
                            priority if (discarding_reg)
                            begin
                                discarding_next = 1'b0;
                                status_next     = lfq_pkg::ST_DISC_END;
                            end
                            else if (asm_len_reg == '0)
                            begin
                                status_next = lfq_pkg::ST_EMPTY_IGN;
                            end
                            else if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                status_next = lfq_pkg::ST_DROP_FULL;
                            end
                            else
                            begin
                                len_wr         = 1'b1;
                                write_row_next = (write_row_reg == ROW_W'(QUEUE_DEPTH))
                                               ? '0 : write_row_reg + ROW_W'(1);
                                count_next     = count_reg + CNT_W'(1);
                                status_next    = lfq_pkg::ST_QUEUED;
                            end
                        end
                        else if (discarding_reg)
                        begin
                            status_next = lfq_pkg::ST_DISCARDED;
                        end
                        else if (asm_len_reg >= COL_W'(MAX_LINE - 1))
                        begin
                            discarding_next = 1'b1;
                            asm_len_next    = '0;
                            status_next     = lfq_pkg::ST_DISC_START;
                        end
                        else
                        begin
                            wr_en        = 1'b1;
                            asm_len_next = asm_len_reg + COL_W'(1);
                            status_next  = lfq_pkg::ST_STORED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = lfq_pkg::ST_QUEUE_EMPTY;
                    end
                    else if (reader_capacity <= 7'(head_len))
                    begin
                        status_next = lfq_pkg::ST_BUF_SMALL;
                    end
                    else
                    begin
                        // line is streamed from the next cycle on
                        strobe_next   = 1'b0;
                        state_next    = lfq_pkg::FSM_STREAM;
                        pop_row_next  = read_row_reg;
                        col_next      = '0;
                        len_m1_next   = head_len - COL_W'(1);
                        read_row_next = (read_row_reg == ROW_W'(QUEUE_DEPTH))
                                      ? '0 : read_row_reg + ROW_W'(1);
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
            end
            lfq_pkg::FSM_STREAM:
            begin
                strobe_next = 1'b1;
                sel_next    = 1'b1;
                status_next = lfq_pkg::ST_LINE_BYTE;
                last_next   = (col_reg == len_m1_reg);
                if (col_reg == len_m1_reg)
                begin
                    state_next = lfq_pkg::FSM_IDLE;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            default:
            begin
                state_next = lfq_pkg::FSM_IDLE;
            end
        endcase

        count_ext  = {3'b000, count_next};
        lines_next = strobe_next ? count_ext[2:0] : lines_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lfq_pkg::FSM_IDLE;
            asm_len_reg    <= '0;
            discarding_reg <= 1'b0;
            read_row_reg   <= '0;
            write_row_reg  <= '0;
            pop_row_reg    <= '0;
            count_reg      <= '0;
            col_reg        <= '0;
            len_m1_reg     <= '0;
            strobe_reg     <= 1'b0;
            status_reg     <= lfq_pkg::ST_STORED;
            last_reg       <= 1'b0;
            sel_reg        <= 1'b0;
            lines_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            asm_len_reg    <= asm_len_next;
            discarding_reg <= discarding_next;
            read_row_reg   <= read_row_next;
            write_row_reg  <= write_row_next;
            pop_row_reg    <= pop_row_next;
            count_reg      <= count_next;
            col_reg        <= col_next;
            len_m1_reg     <= len_m1_next;
            strobe_reg     <= strobe_next;
            status_reg     <= status_next;
            last_reg       <= last_next;
            sel_reg        <= sel_next;
            lines_reg      <= lines_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_wr)
        begin
            lengths_reg[write_row_reg] <= asm_len_reg;
        end
    end

    assign busy          = (state_reg == lfq_pkg::FSM_STREAM);
    assign strobe        = strobe_reg;
    assign status        = status_reg;
    assign line_byte     = sel_reg ? rd_data : 8'h00;
    assign last          = last_reg;
    assign lines_waiting = lines_reg;

    // queue never holds more lines than it has slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("line count above queue depth");

    // pop on an empty ring answers on the next cycle
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action && (count_reg == '0))
        |=> (strobe_reg && (status_reg == lfq_pkg::ST_QUEUE_EMPTY) && last_reg))
        else $error("empty pop not reported");

    // read counter stays inside the line being streamed
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (col_reg <= len_m1_reg))
        else $error("stream counter past line end");

    // every stream cycle is followed by a streamed byte
    a_byte_source: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfq_pkg::FSM_STREAM) |=> (strobe_reg && sel_reg))
        else $error("stream cycle without result");

endmodule

FILE: rtl/lfq_line_store.sv
// ============================================================================
// lfq_line_store
// Byte store for the line rows: one write port, one registered read port.
// ============================================================================
module lfq_line_store #(
    parameter int ROWS  = 5,
    parameter int ROW_W = 3,
    parameter int COL_W = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [ROW_W-1:0] wr_row,
    input  logic [COL_W-1:0] wr_col,
    input  logic [7:0]       wr_data,
    input  logic [ROW_W-1:0] rd_row,
    input  logic [COL_W-1:0] rd_col,
    output logic [7:0]       rd_data
);

    localparam int DEPTH = ROWS << COL_W;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{wr_row, wr_col}] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[{rd_row, rd_col}];
    end

    assign rd_data = rd_data_reg;

endmodule
